/* hdl/assert_macros.svh */
// Assertion macros used by the checker file.
// No dependencies; taken in by `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define ACD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("acd check failed");

// Next-cycle implication, off while reset is high.
`define ACD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("acd check failed");

`endif

/* hdl/acd_pkg.sv */
// Constants and double-precision helpers for the arbitrage cycle detector.
// No dependencies.
package acd_pkg;

  localparam logic [63:0] DBL_ZERO      = 64'h0000_0000_0000_0000;
  localparam logic [63:0] DBL_ONE       = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] DBL_MINUS_ONE = 64'hBFF0_0000_0000_0000;
  localparam logic [63:0] DBL_QNAN      = 64'h7FF8_0000_0000_0000;

  localparam logic [5:0] VC_RESET         = 6'd32;
  localparam logic [0:0] REG_VERTEX_COUNT = 1'b0;

  function automatic logic dbl_is_nan(input logic [63:0] x);
    return (x[62:52] == 11'h7FF) && (x[51:0] != 52'd0);
  endfunction

  // IEEE x < y: false on NaN, +0 and -0 equal.
  function automatic logic dbl_less(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] kx;
    logic [63:0] ky;
    kx = x[63] ? ~x : {1'b1, x[62:0]};
    ky = y[63] ? ~y : {1'b1, y[62:0]};
    return !dbl_is_nan(x) && !dbl_is_nan(y) &&
           !((x[62:0] == 63'd0) && (y[62:0] == 63'd0)) && (kx < ky);
  endfunction

endpackage

/* hdl/acd_edge_if.sv */
// Edge request channel: one matrix entry per request.
// No dependencies.
interface acd_edge_if;
  logic        valid;
  logic        ready;
  logic [4:0]  from_vertex;
  logic [4:0]  to_vertex;
  logic [63:0] rate_bits;
  logic        last_edge;

  modport source(output valid, output from_vertex, output to_vertex,
                 output rate_bits, output last_edge, input ready);
  modport sink(input valid, input from_vertex, input to_vertex,
               input rate_bits, input last_edge, output ready);
endinterface

/* hdl/acd_result_if.sv */
// Result channel: one verdict per search.
// No dependencies.
interface acd_result_if;
  logic valid;
  logic ready;
  logic cycle_found;

  modport source(output valid, output cycle_found, input ready);
  modport sink(input valid, input cycle_found, output ready);
endinterface

/* hdl/acd_fmul.sv */
// Iterative IEEE double multiplier, round to nearest even, full subnormal support.
// Depends on acd_pkg.
module acd_fmul import acd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] p
);

  typedef enum logic [2:0] {F_IDLE, F_MUL, F_NORM_L, F_NORM_R, F_ROUND} fstate_t;

  fstate_t            state;
  logic [2:0]         step;
  logic [52:0]        opa;
  logic [52:0]        opb;
  logic [53:0]        prod;
  logic [105:0]       acc;
  logic signed [12:0] expo;
  logic               sticky;
  logic               sgn;

  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [26:0] mul_x, mul_y;
  logic [53:0] mul_out;
  logic [105:0] addend;
  logic        inc;
  logic [53:0] mant;
  logic signed [12:0] exp_r;
  logic [51:0] frac;
  logic [63:0] rounded;

  assign a_nan  = dbl_is_nan(a);
  assign b_nan  = dbl_is_nan(b);
  assign a_inf  = (a[62:52] == 11'h7FF) && (a[51:0] == 52'd0);
  assign b_inf  = (b[62:52] == 11'h7FF) && (b[51:0] == 52'd0);
  assign a_zero = (a[62:0] == 63'd0);
  assign b_zero = (b[62:0] == 63'd0);

  // 27x27 partial products, low halves first
  always_comb begin
    case (step[1:0])
      2'd0: begin mul_x = opa[26:0];         mul_y = opb[26:0];         end
      2'd1: begin mul_x = opa[26:0];         mul_y = {1'b0, opb[52:27]}; end
      2'd2: begin mul_x = {1'b0, opa[52:27]}; mul_y = opb[26:0];         end
      default: begin mul_x = {1'b0, opa[52:27]}; mul_y = {1'b0, opb[52:27]}; end
    endcase
  end
  assign mul_out = mul_x * mul_y;

  // the product registered last cycle belongs to step-1
  always_comb begin
    case (step)
      3'd1:      addend = {52'd0, prod};
      3'd2, 3'd3: addend = {52'd0, prod} << 27;
      3'd4:      addend = {52'd0, prod} << 54;
      default:   addend = '0;
    endcase
  end

  always_comb begin
    inc   = acc[52] & ((|acc[51:0]) | sticky | acc[53]);
    mant  = {1'b0, acc[105:53]} + 54'(inc);
    exp_r = mant[53] ? expo + 13'sd1 : expo;
    frac  = mant[53] ? mant[52:1] : mant[51:0];
    if (exp_r > 13'sd2046) begin
      rounded = {sgn, 11'h7FF, 52'd0};
    end else begin
      rounded = {sgn, (mant[53] | mant[52]) ? exp_r[10:0] : 11'd0, frac};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        F_IDLE: begin
          if (start) begin
            sgn <= a[63] ^ b[63];
            if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf)) begin
              p    <= DBL_QNAN;
              done <= 1'b1;
            end else if (a_inf || b_inf) begin
              p    <= {a[63] ^ b[63], 11'h7FF, 52'd0};
              done <= 1'b1;
            end else if (a_zero || b_zero) begin
              p    <= {a[63] ^ b[63], 63'd0};
              done <= 1'b1;
            end else begin
              opa    <= {a[62:52] != 11'd0, a[51:0]};
              opb    <= {b[62:52] != 11'd0, b[51:0]};
              expo   <= $signed({2'b00, (a[62:52] == 11'd0) ? 11'd1 : a[62:52]})
                      + $signed({2'b00, (b[62:52] == 11'd0) ? 11'd1 : b[62:52]})
                      - 13'sd1022;
              acc    <= '0;
              sticky <= 1'b0;
              step   <= 3'd0;
              state  <= F_MUL;
            end
          end
        end
        F_MUL: begin
          if (step != 3'd4) prod <= mul_out;
          if (step != 3'd0) acc <= acc + addend;
          if (step == 3'd4) state <= F_NORM_L;
          step <= step + 3'd1;
        end
        F_NORM_L: begin
          if (!acc[105] && (expo > 13'sd1)) begin
            acc  <= acc << 1;
            expo <= expo - 13'sd1;
          end else begin
            state <= F_NORM_R;
          end
        end
        F_NORM_R: begin
          if (expo < 13'sd1) begin
            if (expo < -13'sd60) begin
              // far below the smallest subnormal: rounds to zero
              acc    <= '0;
              sticky <= 1'b1;
              expo   <= 13'sd1;
            end else begin
              acc    <= acc >> 1;
              sticky <= sticky | acc[0];
              expo   <= expo + 13'sd1;
            end
          end else begin
            state <= F_ROUND;
          end
        end
        F_ROUND: begin
          p     <= rounded;
          done  <= 1'b1;
          state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

/* hdl/acd_rate_mem.sv */
// Rate matrix storage: one write port, one registered read port.
// No dependencies.
module acd_rate_mem #(
  parameter int AW = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] wa,
  input  logic [63:0]   wd,
  input  logic [AW-1:0] ra,
  output logic [63:0]   rd
);

  logic [63:0] mem [1 << AW];

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd <= mem[ra];
  end

endmodule

/* hdl/acd_search.sv */
// Bellman-Ford sequencer: best-value memory, relaxation control, compare.
// Depends on acd_pkg and acd_fmul; reads the rate matrix through a port.
module acd_search import acd_pkg::*; #(
  parameter int MAX_VERTICES = 32,
  parameter int VW           = 5,
  parameter int NW           = 6
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [NW-1:0]   n,
  output logic [2*VW-1:0] mat_ra,
  input  logic [63:0]     mat_rd,
  output logic            done,
  output logic            found
);

  typedef enum logic [2:0] {S_IDLE, S_START, S_SRC, S_READ, S_EVAL, S_MUL} sstate_t;

  sstate_t state;
  logic [VW-1:0] src, k, u, v;
  logic [VW-1:0] nm1;

  logic [63:0] best_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] best_ok;
  logic [63:0] bu_raw, bv_raw;
  logic        oku, okv;
  logic [63:0] bu, bv;

  logic          best_we;
  logic [VW-1:0] best_wa;
  logic [63:0]   best_wd;

  logic        skip, probe, improve, adv;
  logic        mul_start, mul_done;
  logic [63:0] mul_p;

  assign nm1    = VW'(n - NW'(1));
  assign mat_ra = {v, u};
  assign bu     = oku ? bu_raw : DBL_MINUS_ONE;
  assign bv     = okv ? bv_raw : DBL_MINUS_ONE;
  assign probe  = (k == nm1);
  assign skip   = (mat_rd[62:0] == 63'd0) || (bu == DBL_MINUS_ONE);
  assign improve = dbl_less(bv, mul_p);
  assign mul_start = (state == S_EVAL) && !skip;
  assign adv = ((state == S_EVAL) && skip) ||
               ((state == S_MUL) && mul_done && !(improve && probe));

  always_comb begin
    best_we = 1'b0;
    best_wa = v;
    best_wd = mul_p;
    if (state == S_SRC) begin
      best_we = 1'b1;
      best_wa = src;
      best_wd = DBL_ONE;
    end else if ((state == S_MUL) && mul_done && improve && !probe) begin
      best_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (best_we) best_mem[best_wa] <= best_wd;
    bu_raw <= best_mem[u];
    bv_raw <= best_mem[v];
  end

  acd_fmul u_fmul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (bu),
    .b     (mat_rd),
    .done  (mul_done),
    .p     (mul_p)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      best_ok <= '0;
      oku     <= 1'b0;
      okv     <= 1'b0;
      done    <= 1'b0;
      found   <= 1'b0;
    end else begin
      done <= 1'b0;
      oku  <= best_ok[u];
      okv  <= best_ok[v];
      if (best_we) best_ok[best_wa] <= 1'b1;
      case (state)
        S_IDLE: begin
          if (start) state <= S_START;
        end
        S_START: begin
          best_ok <= '0;
          src     <= '0;
          if (n == '0) begin
            found <= 1'b0;
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_SRC;
          end
        end
        S_SRC: begin
          k     <= '0;
          u     <= '0;
          v     <= '0;
          state <= S_READ;
        end
        S_READ:  state <= S_EVAL;
        S_EVAL:  if (!skip) state <= S_MUL;
        S_MUL: begin
          if (mul_done && improve && probe) begin
            found   <= 1'b1;
            done    <= 1'b1;
            best_ok <= '0;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      // step to the next relaxation in order: v inner, then u, round, source
      if (adv) begin
        state <= S_READ;
        if (v != nm1) begin
          v <= v + VW'(1);
        end else begin
          v <= '0;
          if (u != nm1) begin
            u <= u + VW'(1);
          end else begin
            u <= '0;
            if (!probe) begin
              k <= k + VW'(1);
            end else begin
              best_ok <= '0;
              if (src == nm1) begin
                found <= 1'b0;
                done  <= 1'b1;
                state <= S_IDLE;
              end else begin
                src   <= src + VW'(1);
                state <= S_SRC;
              end
            end
          end
        end
      end
    end
  end

endmodule

/* hdl/arbitrage_cycle_detector.sv */
// Arbitrage cycle detector, top level.
// Depends on acd_pkg, acd_edge_if, acd_result_if, acd_rate_mem, acd_search.
//
// Usage: edge requests arrive on edges, one matrix entry (from, to, IEEE
// double rate, zero meaning no edge) per cycle while ready is high. The
// request marked last_edge is stored and starts the search; one verdict then
// appears on verdict (cycle_found = 1 when some rate cycle multiplies to
// more than one). vertex_count is written over the APB port at byte 0.
// Throughput: one edge per cycle while loading. The search visits
// n * n * n * n relaxations in order through one best-value memory and one
// shared iterative multiplier; a relaxation whose edge or source value is
// absent skips the multiplier, which finishes at once on a zero, infinite or
// NaN operand and normalizes subnormal values step by step.
// After each verdict, and after reset, a clearing pass zeroes the rate matrix,
// all 2^(2*ceil(log2(MAX_VERTICES))) entries (1024 at the default), ready low.
// A verdict waits in the output register while the receiver stalls; loading
// of the next matrix goes on meanwhile, and the next search holds its verdict
// until the register frees.
module arbitrage_cycle_detector import acd_pkg::*; #(
  parameter int MAX_VERTICES = 32
) (
  input  logic               clk,
  input  logic               rst,
  acd_edge_if.sink           edges,
  acd_result_if.source       verdict,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int AW = 2 * VW;

  typedef enum logic [1:0] {T_CLEAR, T_IDLE, T_SEARCH, T_POST} tstate_t;

  tstate_t       state;
  logic [AW-1:0] clr_addr;
  logic [5:0]    vertex_count;
  logic          res_valid;
  logic          res_found;
  logic          found_hold;
  logic          search_start;

  logic          accept;
  logic          in_range;
  logic          mat_we;
  logic [AW-1:0] mat_wa;
  logic [63:0]   mat_wd;
  logic [AW-1:0] mat_ra;
  logic [63:0]   mat_rd;
  logic [NW-1:0] n_use;
  logic          search_done;
  logic          search_found;

  assign edges.ready         = (state == T_IDLE);
  assign accept              = edges.valid & edges.ready;
  assign verdict.valid       = res_valid;
  assign verdict.cycle_found = res_found;
  assign pready              = 1'b1;
  assign prdata              = {26'd0, vertex_count};

  assign in_range = (32'(edges.from_vertex) < MAX_VERTICES) &&
                    (32'(edges.to_vertex) < MAX_VERTICES);

  assign mat_we = (state == T_CLEAR) || (accept && in_range);
  assign mat_wa = (state == T_CLEAR) ? clr_addr
                : {VW'(edges.from_vertex), VW'(edges.to_vertex)};
  assign mat_wd = (state == T_CLEAR) ? DBL_ZERO : edges.rate_bits;

  assign n_use = (32'(vertex_count) > MAX_VERTICES) ? NW'(MAX_VERTICES)
               : NW'(vertex_count);

  acd_rate_mem #(.AW(AW)) u_rate_mem (
    .clk (clk),
    .we  (mat_we),
    .wa  (mat_wa),
    .wd  (mat_wd),
    .ra  (mat_ra),
    .rd  (mat_rd)
  );

  acd_search #(.MAX_VERTICES(MAX_VERTICES), .VW(VW), .NW(NW)) u_search (
    .clk    (clk),
    .rst    (rst),
    .start  (search_start),
    .n      (n_use),
    .mat_ra (mat_ra),
    .mat_rd (mat_rd),
    .done   (search_done),
    .found  (search_found)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= T_CLEAR;
      clr_addr     <= '0;
      vertex_count <= VC_RESET;
      res_valid    <= 1'b0;
      search_start <= 1'b0;
    end else begin
      search_start <= 1'b0;
      if (verdict.valid && verdict.ready) res_valid <= 1'b0;
      case (state)
        T_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == '1) state <= T_IDLE;
        end
        T_IDLE: begin
          if (accept && edges.last_edge) begin
            search_start <= 1'b1;
            state        <= T_SEARCH;
          end
        end
        T_SEARCH: begin
          if (search_done) begin
            found_hold <= search_found;
            state      <= T_POST;
          end
        end
        T_POST: begin
          if (!res_valid || verdict.ready) begin
            res_valid <= 1'b1;
            res_found <= found_hold;
            state     <= T_CLEAR;
          end
        end
        default: state <= T_CLEAR;
      endcase
      if (psel && penable && pwrite && (paddr[2:2] == REG_VERTEX_COUNT)) begin
        vertex_count <= pwdata[5:0];
      end
    end
  end

endmodule

/* hdl/acd_checker.sv */
// Port-level checks for arbitrage_cycle_detector, attached by bind.
// Depends on assert_macros.svh and the top level's ports.
`include "assert_macros.svh"

module acd_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic in_last,
  input logic out_valid,
  input logic out_ready,
  input logic cycle_found
);

  // the last edge starts a search, so no request is taken right after it
  `ACD_ASSERT_NEXT(a_last_blocks, clk, rst, in_valid && in_ready && in_last, !in_ready)
  // clearing pass follows reset
  `ACD_ASSERT_NOW(a_reset_clear, clk, rst, $fell(rst), !in_ready)
  // a fresh verdict comes with the matrix clear
  `ACD_ASSERT_NOW(a_result_busy, clk, rst, $rose(out_valid), !in_ready)
  `ACD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
                   out_valid && $stable(cycle_found))

endmodule

bind arbitrage_cycle_detector acd_checker u_acd_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (edges.valid),
  .in_ready    (edges.ready),
  .in_last     (edges.last_edge),
  .out_valid   (verdict.valid),
  .out_ready   (verdict.ready),
  .cycle_found (verdict.cycle_found)
);
